// ===== design/wrlm_pkg.sv =====
package wrlm_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int WINDOW_W   = 16;
    localparam int REF_W      = 10;
    localparam int LEVEL_W    = 16;
    localparam int MS_W       = 16;
    localparam int RMS_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
    localparam logic [REF_W-1:0]    REF_RESET    = 10'd220;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH   = 4'd0,
        REG_REFERENCE_LEVEL = 4'd1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_SCALE     = 4'd2,
        OP_SQUARE    = 4'd3,
        OP_ACCUM     = 4'd4,
        OP_DIV_INIT  = 4'd5,
        OP_DIV_STEP  = 4'd6,
        OP_ROOT_INIT = 4'd7,
        OP_ROOT_STEP = 4'd8,
        OP_LOG_INIT  = 4'd9,
        OP_LOG_MUL   = 4'd10,
        OP_LOG_STEP  = 4'd11,
        OP_DB_MUL    = 4'd12,
        OP_PUBLISH   = 4'd13
    } t_op;

    typedef struct packed {
        t_op  op;
        logic log_ref;
    } t_cmd;

    typedef struct packed {
        logic window_end;
        logic ms_zero;
        logic out_free;
    } t_status;

endpackage

// ===== design/wrlm_channels.sv =====
interface wrlm_sample_if;
    import wrlm_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wrlm_result_if;
    import wrlm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level_db;
    logic [MS_W-1:0]           mean_square;
    logic [RMS_W-1:0]          rms_value;
    logic                      silent;

    modport source (output valid, output level_db, output mean_square, output rms_value,
                    output silent, input ready);
    modport sink   (input valid, input level_db, input mean_square, input rms_value,
                    input silent, output ready);
endinterface

interface wrlm_cfg_if;
    import wrlm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/wrlm_ctrl.sv =====
module wrlm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output wrlm_pkg::t_cmd    o_cmd,
    input  wrlm_pkg::t_status i_status
);
    import wrlm_pkg::*;

    localparam logic [4:0] DIV_LAST  = 5'd31;
    localparam logic [4:0] ROOT_LAST = 5'd15;
    localparam logic [4:0] LOG_LAST  = 5'd15;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_SCALE     = 14'b00000000000010,
        S_SQUARE    = 14'b00000000000100,
        S_ACCUM     = 14'b00000000001000,
        S_DECIDE    = 14'b00000000010000,
        S_DIV_INIT  = 14'b00000000100000,
        S_DIV       = 14'b00000001000000,
        S_ROOT_INIT = 14'b00000010000000,
        S_ROOT      = 14'b00000100000000,
        S_LOG_INIT  = 14'b00001000000000,
        S_LOG_MUL   = 14'b00010000000000,
        S_LOG_STEP  = 14'b00100000000000,
        S_DB        = 14'b01000000000000,
        S_PUBLISH   = 14'b10000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_log_ref, n_log_ref;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_log_ref   = r_log_ref;
        o_cmd.op      = OP_NONE;
        o_cmd.log_ref = r_log_ref;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_state  = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.op = OP_SQUARE;
                n_state  = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.op = OP_ACCUM;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = i_status.window_end ? S_DIV_INIT : S_IDLE;
            end
            S_DIV_INIT: begin
                o_cmd.op  = OP_DIV_INIT;
                n_step    = '0;
                n_log_ref = 1'b0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == DIV_LAST) begin
                    n_state = S_ROOT_INIT;
                end
            end
            S_ROOT_INIT: begin
                n_step = '0;
                if (i_status.ms_zero) begin
                    n_state = S_PUBLISH;
                end else begin
                    o_cmd.op = OP_ROOT_INIT;
                    n_state  = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == ROOT_LAST) begin
                    n_step  = '0;
                    n_state = S_LOG_INIT;
                end
            end
            S_LOG_INIT: begin
                o_cmd.op = OP_LOG_INIT;
                n_step   = '0;
                n_state  = S_LOG_MUL;
            end
            S_LOG_MUL: begin
                o_cmd.op = OP_LOG_MUL;
                n_state  = S_LOG_STEP;
            end
            S_LOG_STEP: begin
                o_cmd.op = OP_LOG_STEP;
                n_step   = r_step + 5'd1;
                n_state  = S_LOG_MUL;
                if (r_step == LOG_LAST) begin
                    if (r_log_ref) begin
                        n_state = S_DB;
                    end else begin
                        n_log_ref = 1'b1;
                        n_state   = S_LOG_INIT;
                    end
                end
            end
            S_DB: begin
                o_cmd.op = OP_DB_MUL;
                n_state  = S_PUBLISH;
            end
            S_PUBLISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_log_ref <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_log_ref <= n_log_ref;
        end
    end

endmodule

// ===== design/wrlm_dp.sv =====
module wrlm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wrlm_pkg::t_cmd                      i_cmd,
    output wrlm_pkg::t_status                   o_status,
    input  logic [wrlm_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic                                i_cfg_valid,
    input  logic [wrlm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wrlm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [wrlm_pkg::LEVEL_W-1:0] o_level_db,
    output logic [wrlm_pkg::MS_W-1:0]           o_mean_square,
    output logic [wrlm_pkg::RMS_W-1:0]          o_rms_value,
    output logic                                o_silent
);
    import wrlm_pkg::*;

    localparam logic [8:0]         SCALE_MUL   = 9'd500;
    localparam logic [10:0]        SCALE_DIV   = 11'd1023;
    localparam logic [8:0]         MID_OFFSET  = 9'd250;
    localparam logic signed [26:0] DB_PER_LOG2 = 27'sd50504453;
    localparam logic signed [48:0] ROUND_BIAS  = 49'sd2147483648;
    localparam logic signed [15:0] LEVEL_FLOOR = 16'sh8000;

    function automatic logic [3:0] msb_index(input logic [15:0] x);
        logic [3:0] idx;
        idx = '0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    logic [WINDOW_W-1:0] r_window;
    logic [REF_W-1:0]    r_ref;
    logic [SAMPLE_W-1:0] r_sample;
    logic [7:0]          r_ad;
    logic [15:0]         r_sq;
    logic [31:0]         r_sum;
    logic [15:0]         r_count;
    logic                r_hit;
    logic [31:0]         r_quo;
    logic [15:0]         r_divisor;
    logic [15:0]         r_rem;
    logic [15:0]         r_sq_src;
    logic [16:0]         r_sq_rem;
    logic [15:0]         r_root;
    logic [30:0]         r_m;
    logic [61:0]         r_prod;
    logic [15:0]         r_frac;
    logic [3:0]          r_log_n;
    logic [19:0]         r_l_ms;
    logic signed [48:0]  r_v;
    logic                r_out_valid;
    logic signed [15:0]  r_level;
    logic [15:0]         r_ms_out;
    logic [15:0]         r_rms_out;
    logic                r_silent;

    logic [18:0]        w_scaled;
    logic [8:0]         w_q0;
    logic [10:0]        w_rem0;
    logic [8:0]         w_q;
    logic [7:0]         w_ad;
    logic [15:0]        w_count_inc;
    logic [15:0]        w_count_next;
    logic [16:0]        w_div_acc;
    logic [16:0]        w_div_diff;
    logic               w_div_fit;
    logic [15:0]        w_ms;
    logic [18:0]        w_sq_acc;
    logic [18:0]        w_sq_trial;
    logic [18:0]        w_sq_diff;
    logic               w_sq_fit;
    logic [9:0]         w_ref_eff;
    logic [15:0]        w_log_x;
    logic [3:0]         w_log_n;
    logic [30:0]        w_log_m;
    logic [19:0]        w_l_ref;
    logic signed [21:0] w_d;
    logic signed [48:0] w_v;
    logic signed [48:0] w_rounded;

    // floor(x / 1023) as x / 1024 plus one correction: the remainder stays below 2 * 1023.
    assign w_scaled     = 19'(r_sample) * 19'(SCALE_MUL);
    assign w_q0         = w_scaled[18:10];
    assign w_rem0       = 11'(w_scaled[9:0]) + 11'(w_q0);
    assign w_q          = w_q0 + 9'(w_rem0 >= SCALE_DIV);
    assign w_ad         = (w_q >= MID_OFFSET) ? 8'(w_q - MID_OFFSET) : 8'(MID_OFFSET - w_q);

    assign w_count_inc  = r_count + 16'd1;
    assign w_count_next = (w_count_inc == '0) ? 16'd1 : w_count_inc;

    assign w_div_acc    = {r_rem, r_quo[31]};
    assign w_div_fit    = (w_div_acc >= {1'b0, r_divisor});
    assign w_div_diff   = w_div_acc - {1'b0, r_divisor};
    assign w_ms         = r_quo[15:0];

    assign w_sq_acc     = {r_sq_rem, r_sq_src[15:14]};
    assign w_sq_trial   = {1'b0, r_root, 2'b01};
    assign w_sq_fit     = (w_sq_acc >= w_sq_trial);
    assign w_sq_diff    = w_sq_acc - w_sq_trial;

    assign w_ref_eff    = (r_ref == '0) ? 10'd1 : r_ref;
    assign w_log_x      = i_cmd.log_ref ? 16'(w_ref_eff) : w_ms;
    assign w_log_n      = msb_index(w_log_x);
    assign w_log_m      = 31'(w_log_x) << (5'd30 - 5'(w_log_n));

    assign w_l_ref      = {r_log_n, r_frac};
    assign w_d          = $signed({2'b00, r_l_ms}) - $signed({1'b0, w_l_ref, 1'b0});
    assign w_v          = w_d * DB_PER_LOG2;
    assign w_rounded    = r_v + ROUND_BIAS;

    assign o_status.window_end = r_hit;
    assign o_status.ms_zero    = (w_ms == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_ref       <= REF_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_WINDOW_LENGTH:   r_window <= i_cfg_data[WINDOW_W-1:0];
                    REG_REFERENCE_LEVEL: r_ref    <= i_cfg_data[REF_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_ACCUM) begin
                r_sum   <= r_sum + 32'(r_sq);
                r_count <= w_count_next;
            end else if (i_cmd.op == OP_DIV_INIT) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (i_cmd.op == OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_sample <= i_sample;
            end
            OP_SCALE: begin
                r_ad <= w_ad;
            end
            OP_SQUARE: begin
                r_sq <= 16'(r_ad) * 16'(r_ad);
            end
            OP_ACCUM: begin
                r_hit <= (w_count_next >= r_window);
            end
            OP_DIV_INIT: begin
                r_quo     <= r_sum;
                r_divisor <= r_count;
                r_rem     <= '0;
            end
            OP_DIV_STEP: begin
                r_quo <= {r_quo[30:0], w_div_fit};
                r_rem <= w_div_fit ? w_div_diff[15:0] : w_div_acc[15:0];
            end
            OP_ROOT_INIT: begin
                r_sq_src <= w_ms;
                r_sq_rem <= '0;
                r_root   <= '0;
            end
            OP_ROOT_STEP: begin
                r_sq_src <= {r_sq_src[13:0], 2'b00};
                r_sq_rem <= w_sq_fit ? w_sq_diff[16:0] : w_sq_acc[16:0];
                r_root   <= {r_root[14:0], w_sq_fit};
            end
            OP_LOG_INIT: begin
                if (i_cmd.log_ref) begin
                    r_l_ms <= {r_log_n, r_frac};
                end
                r_m     <= w_log_m;
                r_log_n <= w_log_n;
                r_frac  <= '0;
            end
            OP_LOG_MUL: begin
                r_prod <= 62'(r_m) * 62'(r_m);
            end
            OP_LOG_STEP: begin
                r_m    <= r_prod[61] ? r_prod[61:31] : r_prod[60:30];
                r_frac <= {r_frac[14:0], r_prod[61]};
            end
            OP_DB_MUL: begin
                r_v <= w_v;
            end
            OP_PUBLISH: begin
                if (w_ms == '0) begin
                    r_level   <= LEVEL_FLOOR;
                    r_ms_out  <= '0;
                    r_rms_out <= '0;
                    r_silent  <= 1'b1;
                end else begin
                    r_level   <= w_rounded[47:32];
                    r_ms_out  <= w_ms;
                    r_rms_out <= r_root;
                    r_silent  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_level_db    = r_level;
    assign o_mean_square = r_ms_out;
    assign o_rms_value   = r_rms_out;
    assign o_silent      = r_silent;

endmodule

// ===== design/windowed_rms_level_meter.sv =====
// Windowed RMS level meter.
// Samples enter on i_sample, one 10-bit converter reading per beat. Each is rescaled
// about mid scale, squared and summed; once the window length is reached, one result
// beat leaves on o_result with the mean square, its square root (8 fraction bits) and
// the level against the reference in 1/256 dB. A zero mean square gives the floor level
// with the silent flag set.
// Registers are written on i_cfg (index 0: window length, index 1: reference level);
// the user must write them only while no sample is in flight: the block itself does
// not enforce it. i_cfg.ready is always high. A sample that closes no window keeps
// i_sample.ready low through the scale, square, accumulate and decide steps after the
// beat is taken; no new beat is taken before then. A sample that closes a window keeps
// it low on through a 32-step restoring divide, a 16-step square root, two logarithms
// of 16 squaring steps each on the squarer they share, a scaling multiply and the
// publish step. A silent window skips the root, the logarithms and the scaling multiply.
// The result sits in an output register, so sampling carries on while the receiver
// stalls; a second result waits until the first beat has been taken. Synchronous reset
// restores the default registers and clears the sum, the count and any pending result.
module windowed_rms_level_meter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wrlm_sample_if.sink  i_sample,
    wrlm_cfg_if.sink     i_cfg,
    wrlm_result_if.source o_result
);
    import wrlm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_sample.ready = w_in_ready;
    assign i_cfg.ready    = 1'b1;

    wrlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    wrlm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sample      (i_sample.sample),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_level_db    (o_result.level_db),
        .o_mean_square (o_result.mean_square),
        .o_rms_value   (o_result.rms_value),
        .o_silent      (o_result.silent)
    );

endmodule

// ===== design/wrlm_checker.sv =====
module wrlm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [wrlm_pkg::LEVEL_W-1:0] i_level_db,
    input logic [wrlm_pkg::MS_W-1:0]           i_mean_square,
    input logic [wrlm_pkg::RMS_W-1:0]          i_rms_value,
    input logic                                i_silent
);
    import wrlm_pkg::*;

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat offered straight after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_level_db) && $stable(i_mean_square)
            && $stable(i_rms_value) && $stable(i_silent))
        else $error("stalled result beat changed");

    a_one_sample_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second sample taken while one is in flight");

    a_silent_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_silent |->
            i_level_db == 16'sh8000 && i_mean_square == '0 && i_rms_value == '0)
        else $error("silent result with non-floor fields");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_silent |->
            i_mean_square != '0 && i_rms_value >= 16'd256 && i_rms_value <= 16'd64000)
        else $error("root outside the range of a non-zero mean square");

endmodule

bind windowed_rms_level_meter wrlm_checker u_wrlm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample.valid),
    .i_in_ready    (i_sample.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_level_db    (o_result.level_db),
    .i_mean_square (o_result.mean_square),
    .i_rms_value   (o_result.rms_value),
    .i_silent      (o_result.silent)
);
